// ----- design/bcba_pkg.sv -----
// ----------------------------------------------------------------------------
// bcba_pkg
// Shared sizes, codes and control structs for the contiguous block allocator.
// ----------------------------------------------------------------------------
package bcba_pkg;

    // Sizing of the disk bitmap, the slot table and the longest run.
    localparam int NUM_BLOCKS  = 128;
    localparam int NUM_SLOTS   = 64;
    localparam int BLOCK_BYTES = 512;
    localparam int MAX_RUN     = 3;

    // Fixed widths of the item fields.
    localparam int LEN_W       = 20;
    localparam int SEL_W       = 6;
    localparam int SLOT_OUT_W  = 6;
    localparam int START_OUT_W = 7;
    localparam int COUNT_OUT_W = 2;

    // Internal widths derived from the sizing.
    localparam int BLK_W    = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W    = $clog2(MAX_RUN + 1);
    localparam int SCAN_LEN = (NUM_BLOCKS > NUM_SLOTS) ? NUM_BLOCKS : NUM_SLOTS;
    localparam int SCAN_W   = (SCAN_LEN > 1) ? $clog2(SCAN_LEN) : 1;
    localparam int RAM_W    = BLK_W + CNT_W;

    // Blocks 0 and 1 are reserved out of reset.
    localparam logic [NUM_BLOCKS-1:0] BLOCK_RESET = NUM_BLOCKS'(2'b11);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_NO_SLOT  = 2'd2,
        ST_NOT_USED = 2'd3
    } status_t;

    typedef enum logic {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic decide;
        logic free_slot;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
    } dp_stat_t;

endpackage

// ----- design/bitmap_contiguous_block_allocator.sv -----
// ----------------------------------------------------------------------------
// bitmap_contiguous_block_allocator
// First-fit allocator of contiguous disk blocks over a used-block bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken at a rising edge with start high and busy low. With
//   operation low it allocates length_bytes / 512 + 1 blocks (at most three)
//   for the lowest free slot; with operation high it frees slot_select.
//   The result is on status, slot_out, start_block and block_count for one
//   cycle while done is high; it cannot be held off.
// Sequence:
//   A free reads the slot table on accept; the free state then releases the
//   entry and the result register raises done. An allocate scans one slot
//   entry and one bitmap bit per cycle and stops as soon as both a free slot
//   and a long enough run are known, or all 128 entries are seen; the decide
//   state then registers the result. The scan loop sets the rate.
//   busy drops in the cycle done is high, so the next item can be taken then.
// Reset:
//   Blocks 0 and 1 come out of reset used, all other blocks free, all slots
//   free. No clearing pass is needed.
// ----------------------------------------------------------------------------
module bitmap_contiguous_block_allocator
    import bcba_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   operation,
    input  logic [LEN_W-1:0]       length_bytes,
    input  logic [SEL_W-1:0]       slot_select,
    output logic                   done,
    output logic [1:0]             status,
    output logic [SLOT_OUT_W-1:0]  slot_out,
    output logic [START_OUT_W-1:0] start_block,
    output logic [COUNT_OUT_W-1:0] block_count
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bcba_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .stat      (stat),
        .cmd       (cmd),
        .busy      (busy)
    );

    bcba_dpath u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .length_bytes (length_bytes),
        .slot_select  (slot_select),
        .done         (done),
        .status       (status),
        .slot_out     (slot_out),
        .start_block  (start_block),
        .block_count  (block_count)
    );

    // A result only appears once the sequencer is back to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("Result strobe while the allocator is busy.");

    // A free item always reports through the free state and the result register.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && operation) |-> ##2 done)
        else $error("Free item did not report on time.");

    // The sequencer issues at most one datapath command per cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.scan, cmd.decide, cmd.free_slot}))
        else $error("More than one datapath command in a cycle.");

    // A taken item always makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("Accepted item did not make the block busy.");

endmodule

// ----- design/bcba_ram.sv -----
// ----------------------------------------------------------------------------
// bcba_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module bcba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     clk,
    input  logic                                     wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                         wr_data,
    input  logic                                     rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/bcba_ctrl.sv -----
// ----------------------------------------------------------------------------
// bcba_ctrl
// Sequencer for the allocator: accepts an item, runs the scan or the free
// and hands the datapath at most one command per cycle.
// ----------------------------------------------------------------------------
module bcba_ctrl
    import bcba_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     operation,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DECIDE = 4'b0100,
        S_FREE   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = (op_t'(operation) == OP_FREE) ? S_FREE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = S_IDLE;
            end
            S_FREE:
            begin
                cmd.free_slot = 1'b1;
                state_next    = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// ----- design/bcba_dpath.sv -----
// ----------------------------------------------------------------------------
// bcba_dpath
// Bitmap, slot table and scan counters of the allocator, plus the result
// register.
// ----------------------------------------------------------------------------
module bcba_dpath
    import bcba_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                cmd,
    output dp_stat_t               stat,
    input  logic [LEN_W-1:0]       length_bytes,
    input  logic [SEL_W-1:0]       slot_select,
    output logic                   done,
    output logic [1:0]             status,
    output logic [SLOT_OUT_W-1:0]  slot_out,
    output logic [START_OUT_W-1:0] start_block,
    output logic [COUNT_OUT_W-1:0] block_count
);

    // Bitmap and slot valid bits live in flops so reset can set them at once.
    logic [NUM_BLOCKS-1:0] block_used_reg, block_used_next;
    logic [NUM_SLOTS-1:0]  slot_valid_reg, slot_valid_next;

    // Scan state.
    logic [SCAN_W-1:0] scan_idx_reg, scan_idx_next;
    logic [CNT_W-1:0]  run_len_reg, run_len_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              slot_found_reg, slot_found_next;
    logic              run_found_reg, run_found_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [BLK_W-1:0]  run_start_reg, run_start_next;
    logic [SEL_W-1:0]  sel_reg, sel_next;

    // Result register.
    logic                   done_reg, done_next;
    status_t                status_reg, status_next;
    logic [SLOT_OUT_W-1:0]  slot_out_reg, slot_out_next;
    logic [START_OUT_W-1:0] start_reg, start_next;
    logic [COUNT_OUT_W-1:0] count_reg, count_next;

    // Slot table memory.
    logic              ram_wr_en;
    logic [RAM_W-1:0]  ram_wr_data;
    logic [SLOT_W-1:0] ram_rd_addr;
    logic [RAM_W-1:0]  ram_rd_data;
    logic [BLK_W-1:0]  rd_start;
    logic [CNT_W-1:0]  rd_cnt;

    // Scan helpers.
    logic [CNT_W-1:0]  req_cnt;
    logic [BLK_W-1:0]  blk_idx;
    logic [SLOT_W-1:0] slot_idx;
    logic [SLOT_W-1:0] sel_idx;
    logic [CNT_W:0]    run_inc;
    logic              slot_settled;
    logic              run_settled;
    logic              sel_in_range;
    logic [BLK_W:0]    mark_idx;

    assign blk_idx  = scan_idx_reg[BLK_W-1:0];
    assign slot_idx = scan_idx_reg[SLOT_W-1:0];
    assign sel_idx  = SLOT_W'(sel_reg);
    assign rd_start = ram_rd_data[RAM_W-1:CNT_W];
    assign rd_cnt   = ram_rd_data[CNT_W-1:0];
    assign run_inc  = {1'b0, run_len_reg} + 1'b1;
    assign sel_in_range = (int'(sel_reg) < NUM_SLOTS);

    // Block count from the byte length: one block plus one for every whole
    // block size reached, capped at the longest run.
    always_comb
    begin
        req_cnt = CNT_W'(1);
        for (int k = 1; k < MAX_RUN; k++)
        begin
            if (int'(length_bytes) >= k * BLOCK_BYTES)
            begin
                req_cnt = CNT_W'(k + 1);
            end
        end
    end

    // The scan ends once both the slot search and the run search are settled.
    assign slot_settled = slot_found_next || (scan_idx_reg >= SCAN_W'(NUM_SLOTS - 1));
    assign run_settled  = run_found_next || (scan_idx_reg >= SCAN_W'(NUM_BLOCKS - 1));
    assign stat.scan_done = (slot_settled && run_settled)
                            || (scan_idx_reg == SCAN_W'(SCAN_LEN - 1));

    // Slot table port control: read on accept, write on a successful allocate.
    assign ram_rd_addr = SLOT_W'(slot_select);
    assign ram_wr_en   = cmd.decide && slot_found_reg && run_found_reg;
    assign ram_wr_data = {run_start_reg, cnt_reg};

    bcba_ram #(
        .WIDTH (RAM_W),
        .DEPTH (NUM_SLOTS)
    ) u_slot_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (ram_wr_data),
        .rd_en   (cmd.load),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Main datapath update.
    always_comb
    begin
        block_used_next = block_used_reg;
        slot_valid_next = slot_valid_reg;
        scan_idx_next   = scan_idx_reg;
        run_len_next    = run_len_reg;
        cnt_next        = cnt_reg;
        slot_found_next = slot_found_reg;
        run_found_next  = run_found_reg;
        slot_next       = slot_reg;
        run_start_next  = run_start_reg;
        sel_next        = sel_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        slot_out_next   = slot_out_reg;
        start_next      = start_reg;
        count_next      = count_reg;
        mark_idx        = '0;

        // A new item clears the scan state and latches its fields.
        if (cmd.load)
        begin
            scan_idx_next   = '0;
            run_len_next    = '0;
            cnt_next        = req_cnt;
            slot_found_next = 1'b0;
            run_found_next  = 1'b0;
            sel_next        = slot_select;
        end

        // One slot entry and one bitmap bit per cycle.
        if (cmd.scan)
        begin
            if (!slot_found_reg && (int'(scan_idx_reg) < NUM_SLOTS)
                && !slot_valid_reg[slot_idx])
            begin
                slot_found_next = 1'b1;
                slot_next       = slot_idx;
            end
            if (!run_found_reg && (int'(scan_idx_reg) < NUM_BLOCKS))
            begin
                if (block_used_reg[blk_idx])
                begin
                    run_len_next = '0;
                end
                else
                begin
                    run_len_next = run_inc[CNT_W-1:0];
                    if (run_inc == {1'b0, cnt_reg})
                    begin
                        run_found_next = 1'b1;
                        run_start_next = blk_idx - BLK_W'(cnt_reg) + 1'b1;
                    end
                end
            end
            scan_idx_next = scan_idx_reg + 1'b1;
        end

        // End of an allocate: report a failure or claim the run and the slot.
        if (cmd.decide)
        begin
            done_next     = 1'b1;
            slot_out_next = '0;
            start_next    = '0;
            count_next    = '0;
            if (!slot_found_reg)
            begin
                status_next = ST_NO_SLOT;
            end
            else if (!run_found_reg)
            begin
                status_next = ST_NO_SPACE;
            end
            else
            begin
                status_next = ST_OK;
                for (int k = 0; k < MAX_RUN; k++)
                begin
                    mark_idx = {1'b0, run_start_reg} + (BLK_W + 1)'(k);
                    if ((k < int'(cnt_reg)) && (int'(mark_idx) < NUM_BLOCKS))
                    begin
                        block_used_next[mark_idx[BLK_W-1:0]] = 1'b1;
                    end
                end
                slot_valid_next[slot_reg] = 1'b1;
                slot_out_next = SLOT_OUT_W'(slot_reg);
                start_next    = START_OUT_W'(run_start_reg);
                count_next    = COUNT_OUT_W'(cnt_reg);
            end
        end

        // Free: the slot entry was read on accept and is ready now.
        if (cmd.free_slot)
        begin
            done_next     = 1'b1;
            slot_out_next = SLOT_OUT_W'(sel_reg);
            start_next    = '0;
            count_next    = '0;
            if (sel_in_range && slot_valid_reg[sel_idx])
            begin
                status_next = ST_OK;
                for (int k = 0; k < MAX_RUN; k++)
                begin
                    mark_idx = {1'b0, rd_start} + (BLK_W + 1)'(k);
                    if ((k < int'(rd_cnt)) && (int'(mark_idx) < NUM_BLOCKS))
                    begin
                        block_used_next[mark_idx[BLK_W-1:0]] = 1'b0;
                    end
                end
                slot_valid_next[sel_idx] = 1'b0;
                start_next = START_OUT_W'(rd_start);
                count_next = COUNT_OUT_W'(rd_cnt);
            end
            else
            begin
                status_next = ST_NOT_USED;
            end
        end
    end

    // Control state and bitmap with reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_used_reg <= BLOCK_RESET;
            slot_valid_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            block_used_reg <= block_used_next;
            slot_valid_reg <= slot_valid_next;
            done_reg       <= done_next;
        end
    end

    // Working and payload registers.
    always_ff @(posedge clk)
    begin
        scan_idx_reg   <= scan_idx_next;
        run_len_reg    <= run_len_next;
        cnt_reg        <= cnt_next;
        slot_found_reg <= slot_found_next;
        run_found_reg  <= run_found_next;
        slot_reg       <= slot_next;
        run_start_reg  <= run_start_next;
        sel_reg        <= sel_next;
        status_reg     <= status_next;
        slot_out_reg   <= slot_out_next;
        start_reg      <= start_next;
        count_reg      <= count_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign slot_out    = slot_out_reg;
    assign start_block = start_reg;
    assign block_count = count_reg;

endmodule
